FILE: rtl/core/rbsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants and types for the ray/box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int IDX_W  = 3;
    localparam int THR_W  = 16;
    localparam int DIST_W = 31;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5,
        REG_THRESHOLD = 3'd6
    } t_reg_idx;

    // per-ray flags that ride along the divider pipeline
    typedef struct packed {
        logic [2:0] par;
        logic       cont_ok;
        logic [2:0] neg_lo;
        logic [2:0] neg_hi;
    } t_side;

endpackage

`default_nettype wire

FILE: rtl/core/rbsi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_if
// Channel interfaces: ray input, hit result, configuration write.
// ----------------------------------------------------------------------------
interface rbsi_ray_if #(parameter int CW = rbsi_pkg::COORD_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rbsi_res_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [rbsi_pkg::DIST_W-1:0] hit_distance;
    modport source (output valid, hit, hit_distance, input ready);
    modport sink   (input valid, hit, hit_distance, output ready);
endinterface

interface rbsi_cfg_if #(parameter int CW = rbsi_pkg::COORD_WIDTH_DEF);
    logic                       valid;
    logic                       ready;
    logic [rbsi_pkg::IDX_W-1:0] index;
    logic [CW-1:0]              wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ray_box_slab_intersection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersection
// Slab test of a fixed-point ray against one configured axis-aligned box.
// ----------------------------------------------------------------------------
// One ray is accepted and one result leaves per clock while o_res takes them.
// There is one input stage, a bit-per-stage divider of COORD_WIDTH + 1 +
// FRAC_BITS stages that runs the six plane distances side by side, then
// order, fold and output stages. The whole pipeline holds while a result
// waits on o_res. The user must write box corners and the parallel threshold
// through i_cfg only while no ray is in flight; the block does not check it.
module ray_box_slab_intersection #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rbsi_cfg_if.sink   i_cfg,
    rbsi_ray_if.sink   i_ray,
    rbsi_res_if.source o_res
);
    localparam int CW = COORD_WIDTH;
    localparam int NW = CW + 1 + FRAC_BITS;
    localparam int TW = ((NW > 63) ? NW : 63) + 1;
    localparam logic signed [TW-1:0] TSAT = {{(TW-63){1'b0}}, 1'b1, 62'b0};

    // configuration
    logic signed [CW-1:0]              r_box_min [3];
    logic signed [CW-1:0]              r_box_max [3];
    logic [rbsi_pkg::THR_W-1:0]        r_thr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min <= '{default: '0};
            r_box_max <= '{default: '0};
            r_thr     <= rbsi_pkg::THR_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rbsi_pkg::REG_BOX_MIN_X: r_box_min[0] <= i_cfg.wdata;
                rbsi_pkg::REG_BOX_MIN_Y: r_box_min[1] <= i_cfg.wdata;
                rbsi_pkg::REG_BOX_MIN_Z: r_box_min[2] <= i_cfg.wdata;
                rbsi_pkg::REG_BOX_MAX_X: r_box_max[0] <= i_cfg.wdata;
                rbsi_pkg::REG_BOX_MAX_Y: r_box_max[1] <= i_cfg.wdata;
                rbsi_pkg::REG_BOX_MAX_Z: r_box_max[2] <= i_cfg.wdata;
                rbsi_pkg::REG_THRESHOLD: r_thr <= i_cfg.wdata[rbsi_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the output register is free or being drained
    logic en;
    logic r_out_vld;
    assign en          = !r_out_vld || o_res.ready;
    assign i_ray.ready = en;

    // input stage: plane differences, magnitudes, parallel/containment flags
    logic signed [CW-1:0] ray_o [3];
    logic signed [CW-1:0] ray_d [3];
    logic signed [CW:0]   n_lo  [3];
    logic signed [CW:0]   n_hi  [3];
    logic [CW:0]          m_lo  [3];
    logic [CW:0]          m_hi  [3];
    logic [CW-1:0]        m_d   [3];
    logic [2:0]           fail;
    rbsi_pkg::t_side      side;

    always_comb begin
        ray_o[0] = i_ray.origin_x;
        ray_o[1] = i_ray.origin_y;
        ray_o[2] = i_ray.origin_z;
        ray_d[0] = i_ray.dir_x;
        ray_d[1] = i_ray.dir_y;
        ray_d[2] = i_ray.dir_z;
        for (int a = 0; a < 3; a++) begin
            n_lo[a] = {r_box_min[a][CW-1], r_box_min[a]} - {ray_o[a][CW-1], ray_o[a]};
            n_hi[a] = {r_box_max[a][CW-1], r_box_max[a]} - {ray_o[a][CW-1], ray_o[a]};
            m_lo[a] = n_lo[a][CW] ? (CW+1)'(-n_lo[a]) : n_lo[a];
            m_hi[a] = n_hi[a][CW] ? (CW+1)'(-n_hi[a]) : n_hi[a];
            m_d[a]  = ray_d[a][CW-1] ? CW'(-ray_d[a]) : ray_d[a];
            side.par[a]    = (m_d[a] < CW'(r_thr));
            side.neg_lo[a] = n_lo[a][CW] ^ ray_d[a][CW-1];
            side.neg_hi[a] = n_hi[a][CW] ^ ray_d[a][CW-1];
            fail[a] = side.par[a] &&
                      ((ray_o[a] < r_box_min[a]) || (ray_o[a] > r_box_max[a]));
        end
        side.cont_ok = ~|fail;
    end

    logic            r_e_vld;
    logic [CW:0]     r_e_nlo  [3];
    logic [CW:0]     r_e_nhi  [3];
    logic [CW-1:0]   r_e_den  [3];
    rbsi_pkg::t_side r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= i_ray.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_nlo  <= m_lo;
            r_e_nhi  <= m_hi;
            r_e_den  <= m_d;
            r_e_side <= side;
        end
    end

    // divider bank, one per axis
    logic [NW-1:0] q_lo [3];
    logic [NW-1:0] q_hi [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_div #(
            .CW (CW),
            .FB (FRAC_BITS)
        ) u_div (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_num_lo (r_e_nlo[a]),
            .i_num_hi (r_e_nhi[a]),
            .i_den    (r_e_den[a]),
            .o_quo_lo (q_lo[a]),
            .o_quo_hi (q_hi[a])
        );
    end

    // flags and valid bits matched to the divider depth
    logic            r_dv [NW];
    rbsi_pkg::t_side r_sd [NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '{default: 1'b0};
        end else if (en) begin
            r_dv[0] <= r_e_vld;
            for (int k = 1; k < NW; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_e_side;
            for (int k = 1; k < NW; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    // stage P1: cap, sign, order each axis pair
    logic signed [TW-1:0] c_lo [3];
    logic signed [TW-1:0] c_hi [3];
    logic signed [TW-1:0] s_lo [3];
    logic signed [TW-1:0] s_hi [3];
    logic signed [TW-1:0] n_t1 [3];
    logic signed [TW-1:0] n_t2 [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c_lo[a] = TW'(q_lo[a]);
            c_hi[a] = TW'(q_hi[a]);
            if (c_lo[a] > TSAT) c_lo[a] = TSAT;
            if (c_hi[a] > TSAT) c_hi[a] = TSAT;
            s_lo[a] = r_sd[NW-1].neg_lo[a] ? -c_lo[a] : c_lo[a];
            s_hi[a] = r_sd[NW-1].neg_hi[a] ? -c_hi[a] : c_hi[a];
            if (s_lo[a] > s_hi[a]) begin
                n_t1[a] = s_hi[a];
                n_t2[a] = s_lo[a];
            end else begin
                n_t1[a] = s_lo[a];
                n_t2[a] = s_hi[a];
            end
        end
    end

    logic                 r_p1_vld;
    logic signed [TW-1:0] r_p1_t1 [3];
    logic signed [TW-1:0] r_p1_t2 [3];
    logic [2:0]           r_p1_par;
    logic                 r_p1_cont;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld <= r_dv[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_t1   <= n_t1;
            r_p1_t2   <= n_t2;
            r_p1_par  <= r_sd[NW-1].par;
            r_p1_cont <= r_sd[NW-1].cont_ok;
        end
    end

    // stage P2: fold the non-parallel axes into one interval
    logic signed [TW-1:0] n_tmin;
    logic signed [TW-1:0] n_tmax;

    always_comb begin
        n_tmin = '0;
        n_tmax = TSAT;
        for (int a = 0; a < 3; a++) begin
            if (!r_p1_par[a]) begin
                if (r_p1_t1[a] > n_tmin) n_tmin = r_p1_t1[a];
                if (r_p1_t2[a] < n_tmax) n_tmax = r_p1_t2[a];
            end
        end
    end

    logic                 r_p2_vld;
    logic signed [TW-1:0] r_p2_tmin;
    logic signed [TW-1:0] r_p2_tmax;
    logic                 r_p2_cont;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (en) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_tmin <= n_tmin;
            r_p2_tmax <= n_tmax;
            r_p2_cont <= r_p1_cont;
        end
    end

    // output stage: hit decision and saturation
    logic                          n_hit;
    logic [rbsi_pkg::DIST_W-1:0]   n_dist;
    logic                          r_out_hit;
    logic [rbsi_pkg::DIST_W-1:0]   r_out_dist;

    always_comb begin
        n_hit = r_p2_cont && !(r_p2_tmin > r_p2_tmax);
        if (!n_hit) begin
            n_dist = '0;
        end else if (r_p2_tmin > TW'(rbsi_pkg::DIST_MAX)) begin
            n_dist = rbsi_pkg::DIST_MAX;
        end else begin
            n_dist = r_p2_tmin[rbsi_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit  <= n_hit;
            r_out_dist <= n_dist;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.hit          = r_out_hit;
    assign o_res.hit_distance = r_out_dist;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> o_res.hit_distance == '0)
        else $error("miss result carries a nonzero distance");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ray.ready == (!o_res.valid || o_res.ready))
        else $error("input ready does not track output drain");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("output valid after reset");

    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld |-> (r_p1_t1[0] <= r_p1_t2[0]) && (r_p1_t1[1] <= r_p1_t2[1]) &&
                     (r_p1_t1[2] <= r_p1_t2[2]))
        else $error("slab distances not ordered");

    a_tmin_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> !r_p2_tmin[TW-1])
        else $error("entry distance went negative");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rbsi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, one quotient bit per stage. Two numerators
// share one divisor. Computes (num << FB) / den on magnitudes.
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int CW = rbsi_pkg::COORD_WIDTH_DEF,
    parameter int FB = rbsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [CW:0]         i_num_lo,
    input  wire logic [CW:0]         i_num_hi,
    input  wire logic [CW-1:0]       i_den,
    output logic      [CW+FB:0]      o_quo_lo,
    output logic      [CW+FB:0]      o_quo_hi
);
    localparam int NW = CW + 1 + FB;

    logic [NW-1:0] r_num [NW][2];
    logic [CW-1:0] r_rem [NW][2];
    logic [NW-1:0] r_quo [NW][2];
    logic [CW-1:0] r_den [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [NW-1:0] s_num [2];
        logic [CW-1:0] s_rem [2];
        logic [NW-1:0] s_quo [2];
        logic [CW-1:0] s_den;
        logic [CW:0]   trial [2];
        logic [CW:0]   diff  [2];
        logic [1:0]    ge;

        if (g == 0) begin : g_first
            assign s_num[0] = {i_num_lo, {FB{1'b0}}};
            assign s_num[1] = {i_num_hi, {FB{1'b0}}};
            assign s_rem[0] = '0;
            assign s_rem[1] = '0;
            assign s_quo[0] = '0;
            assign s_quo[1] = '0;
            assign s_den    = i_den;
        end else begin : g_next
            assign s_num[0] = r_num[g-1][0];
            assign s_num[1] = r_num[g-1][1];
            assign s_rem[0] = r_rem[g-1][0];
            assign s_rem[1] = r_rem[g-1][1];
            assign s_quo[0] = r_quo[g-1][0];
            assign s_quo[1] = r_quo[g-1][1];
            assign s_den    = r_den[g-1];
        end

        always_comb begin
            for (int j = 0; j < 2; j++) begin
                trial[j] = {s_rem[j], s_num[j][NW-1]};
                diff[j]  = trial[j] - {1'b0, s_den};
                ge[j]    = (trial[j] >= {1'b0, s_den});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g] <= s_den;
                for (int j = 0; j < 2; j++) begin
                    r_num[g][j] <= {s_num[j][NW-2:0], 1'b0};
                    r_rem[g][j] <= ge[j] ? diff[j][CW-1:0] : trial[j][CW-1:0];
                    r_quo[g][j] <= {s_quo[j][NW-2:0], ge[j]};
                end
            end
        end
    end

    assign o_quo_lo = r_quo[NW-1][0];
    assign o_quo_hi = r_quo[NW-1][1];

endmodule

`default_nettype wire

FILE: tb/tb_ray_box_slab_intersection.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersection
// Checks the slab intersection block against a predictor of its own. Rays come
// from a queue into a clocked driver; a clocked monitor compares each result
// beat with the oldest predicted hit/distance. Box and threshold are rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersection;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = CW + FB + 5;
    localparam int WATCHDOG = 20000;
    localparam logic signed [63:0] T_SAT = 64'sd1 <<< 62;

    typedef struct packed {
        logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;
    } t_ray;
    typedef struct packed {
        logic                        hit;
        logic [rbsi_pkg::DIST_W-1:0] distance;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rbsi_cfg_if #(.CW(CW)) cfg_ch ();
    rbsi_ray_if #(.CW(CW)) ray_ch ();
    rbsi_res_if res_ch ();

    ray_box_slab_intersection #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg(cfg_ch.sink), .i_ray(ray_ch.sink), .o_res(res_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic signed [CW-1:0]       box_lo [3];
    logic signed [CW-1:0]       box_hi [3];
    logic [rbsi_pkg::THR_W-1:0] par_thr;

    t_ray ray_queue [$];
    t_hit hit_queue [$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   errors = 0;
    int   results_seen = 0;
    int   hits_seen = 0;
    int   idle_cycles = 0;

    // quotient of num * 2^FB / den, truncated toward zero, capped at T_SAT
    function automatic logic signed [63:0] slab_div(logic signed [63:0] num,
                                                    logic signed [63:0] den);
        logic [63:0] n, d, q, r;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        for (int k = 0; k < FB; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
            if (q > T_SAT) q = T_SAT;
        end
        if (q > T_SAT) q = T_SAT;
        return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_hit predict_hit(t_ray r);
        logic signed [63:0] org [3];
        logic signed [63:0] dir [3];
        logic signed [63:0] t_in, t_out, t1, t2, lo, hi, tt;
        logic [63:0] dmag;
        logic hit;
        t_hit res;
        org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
        dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
        t_in = 0;
        t_out = T_SAT;
        hit = 1'b1;
        for (int a = 0; a < 3 && hit; a++) begin
            lo = box_lo[a];
            hi = box_hi[a];
            dmag = dir[a] < 0 ? -dir[a] : dir[a];
            if (dmag < par_thr) begin
                if (org[a] < lo || org[a] > hi) hit = 1'b0;
            end else begin
                t1 = slab_div(lo - org[a], dir[a]);
                t2 = slab_div(hi - org[a], dir[a]);
                if (t1 > t2) begin
                    tt = t1; t1 = t2; t2 = tt;
                end
                if (t1 > t_in) t_in = t1;
                if (t2 < t_out) t_out = t2;
                if (t_in > t_out) hit = 1'b0;
            end
        end
        res.hit = hit;
        res.distance = !hit ? '0 :
            (t_in > 64'sh7FFFFFFF ? rbsi_pkg::DIST_MAX : t_in[rbsi_pkg::DIST_W-1:0]);
        return res;
    endfunction

    // driver: hold the beat until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ray_ch.valid <= 1'b0;
        end else if (!ray_ch.valid || ray_ch.ready) begin
            if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_ray r;
                r = ray_queue.pop_front();
                hit_queue.push_back(predict_hit(r));
                {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z,
                 ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z} <= r;
                ray_ch.valid <= 1'b1;
            end else begin
                ray_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= $urandom_range(99) >= recv_idle_pct;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (hit_queue.size() == 0) begin
                $error("result beat with no ray pending: hit=%0b dist=%0d",
                       res_ch.hit, res_ch.hit_distance);
                errors++;
            end else begin
                t_hit e;
                e = hit_queue.pop_front();
                hits_seen += e.hit;
                if (res_ch.hit !== e.hit) begin
                    $error("hit: expected %0b, got %0b", e.hit, res_ch.hit);
                    errors++;
                end
                if (res_ch.hit_distance !== e.distance) begin
                    $error("hit_distance: expected %0d, got %0d", e.distance,
                           res_ch.hit_distance);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(rbsi_pkg::t_reg_idx idx, logic [CW-1:0] value);
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == rbsi_pkg::REG_THRESHOLD) par_thr = value[rbsi_pkg::THR_W-1:0];
        else if (idx <= rbsi_pkg::REG_BOX_MIN_Z) box_lo[idx] = value;
        else box_hi[idx - rbsi_pkg::REG_BOX_MAX_X] = value;
    endtask

    task automatic set_box(logic signed [CW-1:0] lx, ly, lz, hx, hy, hz,
                           logic [rbsi_pkg::THR_W-1:0] thr);
        write_reg(rbsi_pkg::REG_BOX_MIN_X, lx);
        write_reg(rbsi_pkg::REG_BOX_MIN_Y, ly);
        write_reg(rbsi_pkg::REG_BOX_MIN_Z, lz);
        write_reg(rbsi_pkg::REG_BOX_MAX_X, hx);
        write_reg(rbsi_pkg::REG_BOX_MAX_Y, hy);
        write_reg(rbsi_pkg::REG_BOX_MAX_Z, hz);
        write_reg(rbsi_pkg::REG_THRESHOLD, thr);
    endtask

    task automatic drain();
        while (ray_queue.size() > 0 || hit_queue.size() > 0 || ray_ch.valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_ray(logic signed [CW-1:0] ox, oy, oz, dx, dy, dz);
        ray_queue.push_back('{ox, oy, oz, dx, dy, dz});
    endtask

    // coordinate near the box span, sometimes anywhere
    function automatic logic signed [CW-1:0] pick_coord(int a);
        logic signed [63:0] c;
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: begin
                c = box_lo[a] + $signed(64'($urandom_range(32'h40000))) - 64'sh20000;
                if (c > 64'sh7FFFFFFF) c = 64'sh7FFFFFFF;
                if (c < -64'sh80000000) c = -64'sh80000000;
                return c[CW-1:0];
            end
        endcase
    endfunction

    function automatic logic signed [CW-1:0] pick_dir();
        case ($urandom_range(7))
            0: return 0;
            1: return $signed(32'($urandom_range(4))) - 2;
            2: return $urandom;
            3: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed(32'($urandom_range(32'h40000))) - 32'sh20000;
        endcase
    endfunction

    task automatic random_rays(int n);
        for (int i = 0; i < n; i++) begin
            add_ray(pick_coord(0), pick_coord(1), pick_coord(2),
                    pick_dir(), pick_dir(), pick_dir());
        end
    endtask

    task automatic random_box(logic [rbsi_pkg::THR_W-1:0] thr);
        logic signed [CW-1:0] lo [3];
        logic signed [CW-1:0] hi [3];
        for (int a = 0; a < 3; a++) begin
            lo[a] = $signed(32'($urandom_range(32'h80000))) - 32'sh40000;
            hi[a] = lo[a] + $signed(32'($urandom_range(32'h40000)));
            // occasionally invert the box
            if ($urandom_range(15) == 0) hi[a] = lo[a] - 32'sh100;
        end
        set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], thr);
    endtask

    initial begin
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
        ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = 0;
            box_hi[a] = 0;
        end
        par_thr = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset box: a point at the origin, only zero directions are parallel
        add_ray(0, 0, 0, 0, 0, 0);
        add_ray(0, 0, 0, 32'sh10000, 0, 0);
        add_ray(32'sh10000, 0, 0, 0, 0, 0);
        drain();

        // unit box [1,2]^3
        set_box(32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000,
                32'sh20000, 16'd1);
        add_ray(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000);
        add_ray(32'sh18000, 32'sh18000, 32'sh18000, 32'sh10000, 0, 0);
        add_ray(32'sh18000, 32'sh18000, 0, 0, 0, 32'sh10000);
        add_ray(32'sh18000, 32'sh30000, 0, 0, 0, 32'sh10000);
        add_ray(32'sh30000, 32'sh30000, 32'sh30000, 32'shFFFF0000,
                32'shFFFF0000, 32'shFFFF0000);
        add_ray(0, 0, 0, 32'shFFFF0000, 32'shFFFF0000, 32'shFFFF0000);
        add_ray(32'sh80000000, 32'sh18000, 32'sh18000, 1, 0, 0);
        add_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh7FFFFFFF);
        add_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh80000000, 32'sh80000000);
        add_ray(32'sh18000, 32'sh18000, 32'sh18000, 32'sh80000000, 1, -1);
        drain();

        // extreme box, largest threshold, inverted y slab
        set_box(32'sh80000000, 32'sh10000, 32'sh80000000, 32'sh7FFFFFFF, 0,
                32'sh7FFFFFFF, 16'hFFFF);
        add_ray(0, 32'sh8000, 0, 32'shFFFF, 32'sh10000, 32'sh10000);
        add_ray(0, 32'sh8000, 0, 32'sh10000, 32'shFFFF, 32'sh10000);
        add_ray(0, 0, 0, 32'shFFFF0001, 32'sh10000, 32'sh10000);
        add_ray(0, 32'sh20000, 0, 0, 32'shFFFF0000, 0);
        add_ray(32'sh7FFFFFFF, 32'sh80000000, 0, 0, 32'sh10000, 0);
        drain();

        // keep the threshold nonzero so a zero direction is always parallel
        send_idle_pct = 13;
        recv_idle_pct = 83;
        random_box(16'd1);
        random_rays(130);
        drain();
        send_idle_pct = 83;
        recv_idle_pct = 13;
        random_box(16'($urandom_range(16'hFFFF, 1)));
        random_rays(130);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_box(16'($urandom_range(16'h200, 1)));
        random_rays(140);
        drain();
        repeat (LATENCY) @(posedge i_clk);

        $display("Covered %0d rays (%0d hits) over six box settings with stalls",
                 results_seen, hits_seen);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
